>>> rtl/tdf_pkg.sv
package tdf_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int KEEP_BYTES = 32;
  localparam int ADDR_W     = $clog2(KEEP_BYTES);
  localparam int POS_W      = ADDR_W + 1;
  localparam int LEN_W      = 10;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(7);

  localparam int OFS_LAT    = 6;
  localparam int OFS_LON    = 10;
  localparam int OFS_HEIGHT = 14;
  localparam int OFS_VEL_N  = 17;
  localparam int OFS_VEL_E  = 19;
  localparam int OFS_VEL_D  = 21;
  localparam int OFS_SATS   = 23;
  localparam int OFS_FIX    = 24;
  localparam int OFS_RSSI   = 25;

  typedef logic [KEEP_BYTES-1:0][7:0] payload_t;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic              emit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } cmd_t;

endpackage

>>> rtl/tdf_front.sv
module tdf_front import tdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       chunk_end,
  output cmd_t       cmd,
  output logic       cmd_push,
  input  logic       cmd_ready
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_AT   = 3'd1;
  localparam logic [2:0] PH_LEN0 = 3'd2;
  localparam logic [2:0] PH_LEN1 = 3'd3;
  localparam logic [2:0] PH_LEN2 = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;

  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] length_accum, length_accum_next;
  logic             len_invalid, len_invalid_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [POS_W-1:0] payload_pos, payload_pos_next;

  logic             accept;
  logic             want_push;
  logic             is_digit;
  logic [LEN_W-1:0] accum_step;
  logic [LEN_W-1:0] acc_new;
  logic             inv_new;
  logic [LEN_W-1:0] left_dec;

  assign accept   = in_valid && cmd_ready;
  assign in_stall = !cmd_ready;
  assign cmd_push = accept && want_push;

  assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign accum_step = (length_accum << 3) + (length_accum << 1)
                    + {{(LEN_W-4){1'b0}}, rx_byte[3:0]};
  assign acc_new    = is_digit ? accum_step : length_accum;
  assign inv_new    = len_invalid || !is_digit;
  assign left_dec   = (bytes_left != '0) ? bytes_left - LEN_W'(1) : bytes_left;

  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    len_invalid_next  = len_invalid;
    bytes_left_next   = bytes_left;
    payload_pos_next  = payload_pos;
    want_push         = 1'b0;
    cmd               = '0;
    cmd.data          = rx_byte;
    cmd.addr          = payload_pos[ADDR_W-1:0];
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_DOLLAR) begin
          phase_next = PH_AT;
        end
      end
      PH_AT: begin
        if (rx_byte == CH_AT) begin
          want_push         = 1'b1;
          cmd.clear         = 1'b1;
          length_accum_next = '0;
          len_invalid_next  = 1'b0;
          phase_next        = PH_LEN0;
        end else if (rx_byte != CH_DOLLAR) begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN0, PH_LEN1: begin
        length_accum_next = acc_new;
        len_invalid_next  = inv_new;
        phase_next        = phase + 3'd1;
      end
      PH_LEN2: begin
        length_accum_next = acc_new;
        len_invalid_next  = inv_new;
        bytes_left_next   = (inv_new ? '0 : acc_new) + LEN_BIAS;
        payload_pos_next  = '0;
        phase_next        = PH_BODY;
        // chunk ends right at the header: empty frame goes out
        if (chunk_end) begin
          want_push = 1'b1;
          cmd.emit  = 1'b1;
        end
      end
      PH_BODY: begin
        want_push       = 1'b1;
        cmd.wr_en       = payload_pos < POS_W'(KEEP_BYTES);
        cmd.emit        = (left_dec == '0) || chunk_end;
        bytes_left_next = left_dec;
        if (payload_pos < POS_W'(KEEP_BYTES)) begin
          payload_pos_next = payload_pos + POS_W'(1);
        end
        if (left_dec == '0) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
    if (chunk_end) begin
      phase_next = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      length_accum <= '0;
      len_invalid  <= 1'b0;
      bytes_left   <= '0;
      payload_pos  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      len_invalid  <= len_invalid_next;
      bytes_left   <= bytes_left_next;
      payload_pos  <= payload_pos_next;
    end
  end

  a_body_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_left != '0)
    else $error("body phase with no bytes left");

  a_chunk_end_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && chunk_end |=> phase == PH_HUNT)
    else $error("chunk end did not return to hunting");

  a_emit_only_in_body: assert property (@(posedge clk) disable iff (rst)
    cmd_push && cmd.emit |-> (phase == PH_BODY || phase == PH_LEN2) && !cmd.clear)
    else $error("emit word outside payload");

endmodule

>>> rtl/tdf_queue.sv
module tdf_queue import tdf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count overflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count not tracking push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - CNT_W'(1))
    else $error("queue count not tracking pop");

endmodule

>>> rtl/tdf_back.sv
module tdf_back import tdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        date_time,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic [23:0]        height_tenths,
  output logic signed [15:0] north_speed,
  output logic signed [15:0] east_speed,
  output logic signed [15:0] down_speed,
  output logic [7:0]         sat_count,
  output logic [7:0]         fix_byte,
  output logic               position_fresh,
  output logic [55:0]        rssi_text
);

  payload_t    payload;
  payload_t    view;
  logic [31:0] held_lat;
  logic [31:0] held_lon;
  logic [23:0] held_height;
  logic [47:0] held_vel;

  logic        slot_free;
  logic        do_emit;
  logic        fresh;
  logic [31:0] lat_sel, lon_sel;
  logic [23:0] height_sel;
  logic [47:0] vel_sel;

  assign slot_free = !out_valid || !out_stall;
  assign cmd_pop   = cmd_valid && (!cmd.emit || slot_free);
  assign do_emit   = cmd_pop && cmd.emit;

  always_comb begin
    view = payload;
    if (cmd.wr_en) begin
      view[cmd.addr] = cmd.data;
    end
  end

  assign fresh = (view[OFS_SATS] != 8'd0) && (view[OFS_FIX] != 8'd0);

  assign lat_sel    = fresh ? {view[OFS_LAT+3], view[OFS_LAT+2],
                               view[OFS_LAT+1], view[OFS_LAT]} : held_lat;
  assign lon_sel    = fresh ? {view[OFS_LON+3], view[OFS_LON+2],
                               view[OFS_LON+1], view[OFS_LON]} : held_lon;
  assign height_sel = fresh ? {view[OFS_HEIGHT+2], view[OFS_HEIGHT+1],
                               view[OFS_HEIGHT]} : held_height;
  assign vel_sel    = fresh ? {view[OFS_VEL_N+1], view[OFS_VEL_N],
                               view[OFS_VEL_E+1], view[OFS_VEL_E],
                               view[OFS_VEL_D+1], view[OFS_VEL_D]} : held_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload     <= '0;
      held_lat    <= '0;
      held_lon    <= '0;
      held_height <= '0;
      held_vel    <= '0;
    end else if (cmd_pop) begin
      if (cmd.clear) begin
        payload <= '0;
      end else begin
        payload <= view;
      end
      if (do_emit) begin
        held_lat    <= lat_sel;
        held_lon    <= lon_sel;
        held_height <= height_sel;
        held_vel    <= vel_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      date_time      <= {view[0], view[1], view[2], view[3], view[4], view[5]};
      latitude       <= $signed(lat_sel);
      longitude      <= $signed(lon_sel);
      height_tenths  <= height_sel;
      north_speed    <= $signed(vel_sel[47:32]);
      east_speed     <= $signed(vel_sel[31:16]);
      down_speed     <= $signed(vel_sel[15:0]);
      sat_count      <= view[OFS_SATS];
      fix_byte       <= view[OFS_FIX];
      position_fresh <= fresh;
      rssi_text      <= {view[OFS_RSSI], view[OFS_RSSI+1], view[OFS_RSSI+2],
                         view[OFS_RSSI+3], view[OFS_RSSI+4], view[OFS_RSSI+5],
                         view[OFS_RSSI+6]};
    end
  end

  a_fresh_needs_fix: assert property (@(posedge clk) disable iff (rst)
    out_valid && position_fresh |-> sat_count != 8'd0 && fix_byte != 8'd0)
    else $error("fresh position without fix");

  a_stale_is_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_fresh |->
      $unsigned(latitude) == held_lat && height_tenths == held_height)
    else $error("stale position differs from held value");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.clear |=> payload == '0)
    else $error("payload not cleared at frame start");

endmodule

>>> rtl/telemetry_frame_deframer.sv
// Channel | Handshake           | Word
// --------+---------------------+-------------------------------------------
// input   | in_valid / in_stall | rx_byte, chunk_end
// output  | out_valid/out_stall | date_time, latitude, longitude,
//         |                     | height_tenths, north/east/down_speed,
//         |                     | sat_count, fix_byte, position_fresh, rssi_text
//
// One input word per cycle; the framer takes a word whenever the command
// queue has room. The last payload byte of a frame is written into the command
// queue and then assembled into the output register, which takes the frame word
// once it is not held by out_stall.
// Reset clears framer state, queue, payload store and held position.
// in_stall rises only when the command queue is full; that happens when the
// output register is held by out_stall while further payload bytes arrive.
module telemetry_frame_deframer import tdf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               chunk_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        date_time,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic [23:0]        height_tenths,
  output logic signed [15:0] north_speed,
  output logic signed [15:0] east_speed,
  output logic signed [15:0] down_speed,
  output logic [7:0]         sat_count,
  output logic [7:0]         fix_byte,
  output logic               position_fresh,
  output logic [55:0]        rssi_text
);

  cmd_t front_cmd;
  logic front_push;
  logic queue_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_pop;

  tdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .chunk_end (chunk_end),
    .cmd       (front_cmd),
    .cmd_push  (front_push),
    .cmd_ready (queue_ready)
  );

  tdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push       (front_push),
    .push_ready (queue_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop        (back_pop)
  );

  tdf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (back_cmd),
    .cmd_valid      (back_valid),
    .cmd_pop        (back_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .date_time      (date_time),
    .latitude       (latitude),
    .longitude      (longitude),
    .height_tenths  (height_tenths),
    .north_speed    (north_speed),
    .east_speed     (east_speed),
    .down_speed     (down_speed),
    .sat_count      (sat_count),
    .fix_byte       (fix_byte),
    .position_fresh (position_fresh),
    .rssi_text      (rssi_text)
  );

endmodule
